/* src/crcd_pkg.sv */
// ----------------------------------------------------------------------------
// CRC codeword stream decoder package
// Shared types and constants for the decoder: item, result and configuration
// layouts, register indexes and codeword geometry.
// ----------------------------------------------------------------------------
package crcd_pkg;

    localparam int COUNT_BITS     = 16;
    localparam int TOTAL_BITS     = 16;
    localparam int CW_BITS        = 11;
    localparam int NARROW_LEN     = 7;
    localparam int WIDE_LEN       = 11;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GENERATOR     = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE_DATAWORD = 1'd1;

    localparam logic [3:0] GENERATOR_RESET = 4'd11;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CW_BITS-1:0]    codeword_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0]            data_byte;
        logic                  data_valid;
        logic                  done_res;
        logic [TOTAL_BITS-1:0] codeword_total;
        logic [TOTAL_BITS-1:0] error_total;
    } result_t;

    typedef struct packed {
        logic [3:0] generator;
        logic       wide_dataword;
    } cfg_t;

endpackage

/* src/crc_codeword_stream_decoder.sv */
// ----------------------------------------------------------------------------
// CRC codeword stream decoder
// Byte stream in, one result per byte out.
//
// Channels: item (in_byte, last) and result, both valid/ready; a transfer
// happens on a rising edge with valid and ready high. The configuration
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the generator
// (index 0) and the dataword width (index 1); cfg_ready is always high.
// Write configuration only while no stream byte is in flight.
// Each stream starts with a padding byte, then codeword bytes; the byte
// marked last carries the totals and closes the stream.
// An accepted item is held in the input register, then the result register.
// Throughput: one byte per cycle while results are taken, set by the input
// register and the combinational step unit in front of the result register.
// Reset: configuration returns to generator 11 and 4-bit data; the stream
// state and totals clear; no result is held.
// Receiver stall: the result register holds; the input register still takes
// one more byte, then item_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module crc_codeword_stream_decoder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  crcd_pkg::item_t                        item,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output crcd_pkg::result_t                      result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [crcd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [crcd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    logic              hold_valid_reg, hold_valid_next;
    crcd_pkg::item_t   hold_reg;
    logic              result_valid_reg, result_valid_next;
    crcd_pkg::result_t result_reg;
    crcd_pkg::result_t step_result;
    crcd_pkg::cfg_t    cfg_reg;
    logic              advance;

    assign cfg_ready  = 1'b1;
    assign advance    = hold_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !hold_valid_reg || advance;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (item_valid && item_ready)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    crcd_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (hold_reg),
        .cfg         (cfg_reg),
        .result_next (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            hold_reg <= item;
        if (advance)
            result_reg <= step_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.generator     <= crcd_pkg::GENERATOR_RESET;
            cfg_reg.wide_dataword <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crcd_pkg::REG_GENERATOR:     cfg_reg.generator     <= cfg_data[3:0];
                crcd_pkg::REG_WIDE_DATAWORD: cfg_reg.wide_dataword <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

endmodule

/* src/crcd_crc.sv */
// ----------------------------------------------------------------------------
// CRC codeword check
// Modulo-2 division of one 7-bit or 11-bit codeword by the four-bit
// generator; flags a nonzero three-bit remainder.
// ----------------------------------------------------------------------------
module crcd_crc (
    input  crcd_pkg::cfg_t      cfg,
    input  crcd_pkg::codeword_t codeword,
    output logic                error
);

    logic [15:0] window;

    always_comb
    begin
        window = cfg.wide_dataword ? {codeword, 5'b0} : {codeword[6:0], 9'b0};
        for (int s = 0; s < 8; s++)
        begin
            if (s < 4 || cfg.wide_dataword)
            begin
                if (window[15])
                begin
                    window[15:12] = window[15:12] ^ cfg.generator;
                end
                if (s < 3 || (cfg.wide_dataword && s < 7))
                begin
                    window = {window[14:0], 1'b0};
                end
            end
        end
        error = (window[14:12] != 3'b000);
    end

endmodule

/* src/crcd_step.sv */
// ----------------------------------------------------------------------------
// CRC decoder step unit
// Holds the stream state; slices one byte into codewords, checks them,
// packs the data nibbles and forms the result for that byte.
// ----------------------------------------------------------------------------
module crcd_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  crcd_pkg::item_t   item,
    input  crcd_pkg::cfg_t    cfg,
    output crcd_pkg::result_t result_next
);

    localparam logic [1:0] PHASE_PAD   = 2'd0;
    localparam logic [1:0] PHASE_FIRST = 2'd1;
    localparam logic [1:0] PHASE_BODY  = 2'd2;

    localparam int WIDE_BITS = crcd_pkg::COUNT_BITS + crcd_pkg::TOTAL_BITS;

    function automatic crcd_pkg::count_t sat_inc(input crcd_pkg::count_t v);
        if (v != {crcd_pkg::COUNT_BITS{1'b1}})
            return v + crcd_pkg::count_t'(1);
        else
            return v;
    endfunction

    function automatic logic [crcd_pkg::TOTAL_BITS-1:0] show_total(
        input crcd_pkg::count_t v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        if (w > WIDE_BITS'({crcd_pkg::TOTAL_BITS{1'b1}}))
            return {crcd_pkg::TOTAL_BITS{1'b1}};
        else
            return w[crcd_pkg::TOTAL_BITS-1:0];
    endfunction

    logic [1:0]          phase_reg, phase_next;
    logic [3:0]          pad_reg, pad_next;
    crcd_pkg::codeword_t bits_reg, bits_next;
    logic [3:0]          fill_reg, fill_next;
    logic [3:0]          held_reg, held_next;
    logic                pending_reg, pending_next;
    crcd_pkg::count_t    cw_count_reg, cw_count_next;
    crcd_pkg::count_t    err_count_reg, err_count_next;

    logic [3:0]          skip;
    logic [3:0]          len;
    crcd_pkg::codeword_t bits_v;
    logic [3:0]          fill_v;
    crcd_pkg::codeword_t cw_v;
    crcd_pkg::codeword_t pack_cw;
    logic [1:0]          ncw;
    crcd_pkg::codeword_t slot0, slot1;
    logic                err0, err1;
    crcd_pkg::count_t    cw_mid, err_mid, cw_new, err_new;
    logic [3:0]          held_v;
    logic                pending_v;
    logic [7:0]          obyte;
    logic                ovalid;

    always_comb
    begin
        phase_next = phase_reg;
        pad_next   = pad_reg;
        skip       = 4'd8;
        case (phase_reg)
            PHASE_PAD:
            begin
                pad_next   = (item.in_byte > 8'd8) ? 4'd8 : item.in_byte[3:0];
                phase_next = PHASE_FIRST;
            end
            PHASE_FIRST:
            begin
                skip       = pad_reg;
                phase_next = PHASE_BODY;
            end
            PHASE_BODY:
            begin
                skip = 4'd0;
            end
            default:
            begin
                phase_next = PHASE_PAD;
            end
        endcase
    end

    always_comb
    begin
        len    = cfg.wide_dataword ? 4'(crcd_pkg::WIDE_LEN) : 4'(crcd_pkg::NARROW_LEN);
        bits_v = bits_reg;
        fill_v = fill_reg;
        cw_v   = '0;
        ncw    = 2'd0;
        slot0  = '0;
        slot1  = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) >= skip)
            begin
                bits_v = {bits_v[crcd_pkg::CW_BITS-2:0], item.in_byte[7-i]};
                fill_v = fill_v + 4'd1;
                if (fill_v >= len)
                begin
                    cw_v = cfg.wide_dataword ? bits_v : {4'b0, bits_v[6:0]};
                    if (ncw == 2'd0)
                        slot0 = cw_v;
                    else
                        slot1 = cw_v;
                    ncw    = ncw + 2'd1;
                    bits_v = '0;
                    fill_v = 4'd0;
                end
            end
        end
    end

    crcd_crc u_crc0 (
        .cfg      (cfg),
        .codeword (slot0),
        .error    (err0)
    );

    crcd_crc u_crc1 (
        .cfg      (cfg),
        .codeword (slot1),
        .error    (err1)
    );

    always_comb
    begin
        cw_mid  = (ncw != 2'd0) ? sat_inc(cw_count_reg) : cw_count_reg;
        cw_new  = (ncw == 2'd2) ? sat_inc(cw_mid) : cw_mid;
        err_mid = (ncw != 2'd0 && err0) ? sat_inc(err_count_reg) : err_count_reg;
        err_new = (ncw == 2'd2 && err1) ? sat_inc(err_mid) : err_mid;
    end

    always_comb
    begin
        held_v    = held_reg;
        pending_v = pending_reg;
        obyte     = 8'd0;
        ovalid    = 1'b0;
        pack_cw   = '0;
        for (int k = 0; k < 2; k++)
        begin
            if (ncw > 2'(k))
            begin
                pack_cw = (k == 0) ? slot0 : slot1;
                if (cfg.wide_dataword)
                begin
                    if (pending_v)
                    begin
                        obyte  = {held_v, pack_cw[10:7]};
                        held_v = pack_cw[6:3];
                    end
                    else
                    begin
                        obyte = pack_cw[10:3];
                    end
                    ovalid = 1'b1;
                end
                else
                begin
                    if (pending_v)
                    begin
                        obyte     = {held_v, pack_cw[6:3]};
                        pending_v = 1'b0;
                        held_v    = 4'd0;
                        ovalid    = 1'b1;
                    end
                    else
                    begin
                        held_v    = pack_cw[6:3];
                        pending_v = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        result_next.data_byte      = obyte;
        result_next.data_valid     = ovalid;
        result_next.done_res       = item.last;
        result_next.codeword_total = show_total(cw_new);
        result_next.error_total    = show_total(err_new);
    end

    always_comb
    begin
        if (item.last)
        begin
            bits_next      = '0;
            fill_next      = 4'd0;
            held_next      = 4'd0;
            pending_next   = 1'b0;
            cw_count_next  = '0;
            err_count_next = '0;
        end
        else
        begin
            bits_next      = bits_v;
            fill_next      = fill_v;
            held_next      = held_v;
            pending_next   = pending_v;
            cw_count_next  = cw_new;
            err_count_next = err_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_PAD;
            pad_reg       <= 4'd0;
            bits_reg      <= '0;
            fill_reg      <= 4'd0;
            held_reg      <= 4'd0;
            pending_reg   <= 1'b0;
            cw_count_reg  <= '0;
            err_count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= item.last ? PHASE_PAD : phase_next;
            pad_reg       <= item.last ? 4'd0 : pad_next;
            bits_reg      <= bits_next;
            fill_reg      <= fill_next;
            held_reg      <= held_next;
            pending_reg   <= pending_next;
            cw_count_reg  <= cw_count_next;
            err_count_reg <= err_count_next;
        end
    end

endmodule

/* src/crcd_checker.sv */
// ----------------------------------------------------------------------------
// CRC decoder port checker
// Watches the top-level result channel for stall, packing and total rules.
// ----------------------------------------------------------------------------
module crcd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input crcd_pkg::result_t result
);

    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result);
    endproperty
    a_stall_hold: assert property (p_stall_hold)
        else $error("result changed during stall");

    property p_empty_byte;
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result.data_valid |-> result.data_byte == 8'd0;
    endproperty
    a_empty_byte: assert property (p_empty_byte)
        else $error("data byte not zero without data");

    property p_errors_bounded;
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> result.error_total <= result.codeword_total;
    endproperty
    a_errors_bounded: assert property (p_errors_bounded)
        else $error("error total above codeword total");

    property p_restart;
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.done_res
        |=> !result_valid || (result.codeword_total == '0 && result.error_total == '0);
    endproperty
    a_restart: assert property (p_restart)
        else $error("totals not cleared after stream end");

    property p_monotone;
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.done_res
        |=> !result_valid || result.codeword_total >= $past(result.codeword_total);
    endproperty
    a_monotone: assert property (p_monotone)
        else $error("codeword total went down within a stream");

endmodule

bind crc_codeword_stream_decoder crcd_checker u_crcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

/* bench/crcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC codeword stream decoder checker
// Watches the configuration, item and result channels of the decoder. Every
// accepted stream byte runs through a local decoder model that tracks the
// stream phase, codeword assembly, nibble packing and the saturating totals.
// Each accepted result is compared field by field against the oldest
// predicted result. Mismatches are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module crcd_bench_checker
    import crcd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic                      item_ready,
    input  item_t                     item,
    input  logic                      result_valid,
    input  logic                      result_ready,
    input  result_t                   result,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        fail_count,
    output int                        outstanding
);

    typedef enum logic [1:0] {PH_PAD, PH_FIRST, PH_BODY} stream_phase_t;

    localparam count_t COUNT_MAX = '1;

    logic [3:0]    gen_poly;
    logic          wide_mode;
    stream_phase_t phase;
    logic [3:0]    pad_bits;
    codeword_t     cw_shift;
    logic [3:0]    cw_fill;
    logic [3:0]    nibble;
    logic          nibble_held;
    count_t        cw_count;
    count_t        err_count;
    result_t       predicted_results[$];

    function automatic logic [2:0] crc_residue(input codeword_t cw, input int len);
        logic [15:0] x;
        int          steps;
        steps = (len == NARROW_LEN) ? 4 : 8;
        x = 16'(cw) << (16 - len);
        for (int i = 0; i < steps; i++)
        begin
            if (x[15])
                x[15:12] = x[15:12] ^ gen_poly;
            if (i + 1 < steps)
                x = x << 1;
        end
        return x[14:12];
    endfunction

    function automatic count_t bump(input count_t v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOTAL_BITS-1:0] shown(input count_t v);
        return (64'(v) > 64'(16'hFFFF)) ? {TOTAL_BITS{1'b1}} : TOTAL_BITS'(v);
    endfunction

    task automatic clear_stream();
        phase       = PH_PAD;
        pad_bits    = '0;
        cw_shift    = '0;
        cw_fill     = '0;
        nibble      = '0;
        nibble_held = 1'b0;
        cw_count    = '0;
        err_count   = '0;
    endtask

    task automatic decode_byte(input item_t it, output result_t r);
        int         nbits;
        int         len;
        logic       complete;
        logic [7:0] obyte;
        logic [7:0] d;
        codeword_t  cw;
        nbits    = 0;
        complete = 1'b0;
        obyte    = '0;
        case (phase)
            PH_PAD:
            begin
                pad_bits = (it.in_byte > 8'd8) ? 4'd8 : it.in_byte[3:0];
                phase    = PH_FIRST;
            end
            PH_FIRST:
            begin
                nbits = 8 - int'(pad_bits);
                phase = PH_BODY;
            end
            default:
                nbits = 8;
        endcase
        for (int i = nbits; i > 0; i--)
        begin
            len      = wide_mode ? WIDE_LEN : NARROW_LEN;
            cw_shift = {cw_shift[CW_BITS-2:0], it.in_byte[i-1]};
            cw_fill  = cw_fill + 4'd1;
            if (int'(cw_fill) >= len)
            begin
                cw       = cw_shift & codeword_t'((1 << len) - 1);
                cw_shift = '0;
                cw_fill  = '0;
                cw_count = bump(cw_count);
                if (crc_residue(cw, len) != 3'd0)
                    err_count = bump(err_count);
                if (wide_mode)
                begin
                    d = cw[10:3];
                    if (nibble_held)
                    begin
                        obyte  = {nibble, d[7:4]};
                        nibble = d[3:0];
                    end
                    else
                        obyte = d;
                    complete = 1'b1;
                end
                else
                begin
                    d = {4'h0, cw[6:3]};
                    if (nibble_held)
                    begin
                        obyte       = {nibble, d[3:0]};
                        nibble      = '0;
                        nibble_held = 1'b0;
                        complete    = 1'b1;
                    end
                    else
                    begin
                        nibble      = d[3:0];
                        nibble_held = 1'b1;
                    end
                end
            end
        end
        r.data_byte      = complete ? obyte : 8'h00;
        r.data_valid     = complete;
        r.done_res       = it.last;
        r.codeword_total = shown(cw_count);
        r.error_total    = shown(err_count);
        if (it.last)
            clear_stream();
    endtask

    task automatic flag(input string field, input logic [31:0] want_v, input logic [31:0] got_v);
        $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want_v, got_v);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            gen_poly  = GENERATOR_RESET;
            wide_mode = 1'b0;
            clear_stream();
            predicted_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GENERATOR)
                    gen_poly = cfg_data[3:0];
                else if (cfg_index == REG_WIDE_DATAWORD)
                    wide_mode = cfg_data[0];
            end
            if (item_valid && item_ready)
            begin
                decode_byte(item, want);
                predicted_results.push_back(want);
            end
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, %s 0x%0h totals %0d/%0d",
                             $time, "actual data", result.data_byte,
                             result.codeword_total, result.error_total);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result.data_byte !== want.data_byte)
                        flag("data_byte", 32'(want.data_byte), 32'(result.data_byte));
                    if (result.data_valid !== want.data_valid)
                        flag("data_valid", 32'(want.data_valid), 32'(result.data_valid));
                    if (result.done_res !== want.done_res)
                        flag("done_res", 32'(want.done_res), 32'(result.done_res));
                    if (result.codeword_total !== want.codeword_total)
                        flag("codeword_total", 32'(want.codeword_total),
                             32'(result.codeword_total));
                    if (result.error_total !== want.error_total)
                        flag("error_total", 32'(want.error_total), 32'(result.error_total));
                end
            end
        end
        outstanding = predicted_results.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC codeword stream decoder testbench
// Drives byte streams into the decoder in bursts with random gaps while the
// result side stalls on its own pattern. A directed part covers padding
// extremes, single-byte streams, generator extremes and width changes in the
// middle of a stream; the rest is random streams under random
// configurations. Checking is done by the checker instance; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    import crcd_pkg::*;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int RANDOM_ITEMS = 600;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_ready;
    item_t                     item         = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    result_t                   result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

    int   fail_count;
    int   outstanding;
    int   cycles;
    int   burst_left;
    int   sent_items;
    int   stall_mode;
    int   stall_left;
    int   mode_left;

    crc_codeword_stream_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    crcd_bench_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
            mode_left  = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left = mode_left - 1;
            case (stall_mode)
                0: result_ready <= 1'b1;
                1: result_ready <= 1'($urandom_range(0, 1));
                2:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left = stall_left - 1;
                        result_ready <= 1'b0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(1, 25);
                        result_ready <= 1'b1;
                    end
                end
                default: result_ready <= cycles[0];
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        item_valid <= 1'b1;
        item       <= {b, l};
        @(negedge clk);
        while (!item_ready)
            @(negedge clk);
        @(posedge clk);
        sent_items = sent_items + 1;
    endtask

    task automatic cfg_transfer(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_config(input logic [3:0] gen, input logic wide);
        cfg_transfer(REG_GENERATOR, gen);
        cfg_transfer(REG_WIDE_DATAWORD, {3'($urandom), wide});
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_config();
        logic [3:0] gen;
        gen = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
        write_config(gen, 1'($urandom));
    endtask

    // hold off until every transfer has produced its result
    task automatic settle();
        item_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic send_stream();
        int         body;
        int         cut;
        logic [7:0] pad;
        pad  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(9, 255)) : 8'($urandom_range(0, 8));
        body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
        cut  = ($urandom_range(0, 3) == 0 && body > 1) ? $urandom_range(1, body - 1) : -1;
        send_byte(pad, body == 0);
        for (int k = 0; k < body; k++)
        begin
            if (k == cut)
            begin
                settle();
                pick_config();
            end
            send_byte(8'($urandom), k == body - 1);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h0C, 1'b1);

        settle();
        write_config(4'd15, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);

        settle();
        write_config(4'd8, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);

        // switch width and generator in the middle of one stream
        settle();
        write_config(4'd13, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0);
        settle();
        write_config(4'd3, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'h69, 1'b0);
        send_byte(8'h3C, 1'b0);
        settle();
        write_config(GENERATOR_RESET, 1'b1);
        send_byte(8'hE7, 1'b0);
        send_byte(8'h18, 1'b1);

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            settle();
            pick_config();
            repeat ($urandom_range(1, 4)) send_stream();
        end

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* crc_codeword_stream_decoder.f */
src/crcd_pkg.sv
src/crcd_crc.sv
src/crcd_step.sv
src/crc_codeword_stream_decoder.sv
src/crcd_checker.sv
bench/crcd_checker.sv
bench/testbench.sv
